@@ sv/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and reset values of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int NUM_BLOCKS_DEF = 512;
    localparam int ADDR_BITS_DEF  = 32;
    localparam int MIN_BLOCK_LOG2 = 2;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LOG2_W    = 5;
    localparam int CNT_W     = 10;

    localparam logic [31:0]       BASE_RST  = 32'd0;
    localparam logic [31:0]       CAP_RST   = 32'd32768;
    localparam logic [LOG2_W-1:0] SIZE_RST  = 5'd6;
    localparam logic [LOG2_W-1:0] ALIGN_RST = 5'd3;
    localparam logic              DRC_RST   = 1'b1;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESET   = 2'd2,
        OP_CHECK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_NULL      = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DOUBLE    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE       = 3'd0,
        CFG_CAPACITY   = 3'd1,
        CFG_SIZE_LOG2  = 3'd2,
        CFG_ALIGN_LOG2 = 3'd3,
        CFG_DRC        = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      block_address;
        logic             owned;
        logic [CNT_W-1:0] free_blocks;
        logic [CNT_W-1:0] used_blocks;
        logic             pool_empty;
        logic             pool_full;
    } t_out_item;

endpackage

@@ sv/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ sv/fixed_block_pool_allocator_top.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Pool of equal blocks with a LIFO free list held in one RAM word per block
// (successor index and free flag). Acquire pops, release pushes, reset pool
// rebuilds, check tests ownership. Every result beat carries the counts.
//
//   channel  direction  handshake                   beat
//   in       input      i_in_valid / o_in_stall     i_in  (operation, address)
//   out      output     o_out_valid / i_out_stall   o_out (status .. pool_full)
//   cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// Acquire answers in S_RD from the head's link word read from the link RAM;
// release and check pass S_LKA and S_LKB, where check and a null or invalid
// release answer; any other release reads its link word and answers in S_RD.
// Reset pool and any write to registers 0..3 run a count step (S_CNTA, S_CNTB,
// S_CNTC), a sweep writing every RAM entry; reset also runs it before the first
// input beat is taken. A new input beat is taken while a result beat waits
// under i_out_stall; the next result waits until the output register frees.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
    parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF,
    parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fbpa_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fbpa_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]          i_cfg_data
);

    import fbpa_pkg::*;

    localparam int IW  = $clog2(NUM_BLOCKS + 1);
    localparam int AI  = $clog2(NUM_BLOCKS);
    localparam int MW  = IW + 1;
    localparam int XW  = (ADDR_BITS > 32) ? ADDR_BITS : 32;
    localparam int LKW = (XW > IW + 31) ? XW : IW + 31;
    localparam int SW  = LKW + 1;

    localparam logic [IW-1:0] NULL_I = IW'(NUM_BLOCKS);
    localparam logic [IW-1:0] LAST_I = IW'(NUM_BLOCKS - 1);
    localparam logic [XW-1:0] AMASK  = XW'({ADDR_BITS{1'b1}});

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CNTA  = 8'b0000_0010,
        S_CNTB  = 8'b0000_0100,
        S_CNTC  = 8'b0000_1000,
        S_SWEEP = 8'b0001_0000,
        S_LKA   = 8'b0010_0000,
        S_LKB   = 8'b0100_0000,
        S_RD    = 8'b1000_0000
    } t_state;

    function automatic t_out_item mk_out(input t_status st, input logic [31:0] ba,
                                         input logic own, input logic [IW-1:0] fr,
                                         input logic [IW-1:0] cnt);
        t_out_item o;
        logic [IW-1:0] used;
        used            = cnt - fr;
        o.status        = st;
        o.block_address = ba;
        o.owned         = own;
        o.free_blocks   = CNT_W'(fr);
        o.used_blocks   = CNT_W'(used);
        o.pool_empty    = (used == '0);
        o.pool_full     = (fr == '0);
        return o;
    endfunction

    t_state r_state, n_state;

    logic [31:0]       r_base;
    logic [31:0]       r_cap;
    logic [LOG2_W-1:0] r_slog;
    logic [LOG2_W-1:0] r_alog;
    logic              r_drc;

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_free, n_free;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_swp, n_swp;
    logic          r_rbitem, n_rbitem;

    logic [1:0]    r_op;
    logic [XW-1:0] r_addr;
    logic [31:0]   r_raddr;
    logic          r_exh;
    logic [IW-1:0] r_idx;
    logic          r_lt;
    logic [XW-1:0] r_off;
    logic [XW-1:0] r_space;
    logic [IW-1:0] r_ncap;
    logic [XW-1:0] r_rem;
    logic          r_under;

    logic      r_ovalid;
    t_out_item r_out;
    logic      put;
    t_out_item put_item;

    logic          ram_we, ram_re;
    logic [AI-1:0] ram_waddr, ram_raddr;
    logic [MW-1:0] ram_wdata, ram_rdata;

    logic          acc, out_free, cfg_rebuild, cfg_ok;
    logic [XW-1:0] base_x, sz_m1, fit;
    logic [31:0]   cap_sh;
    logic [LKW-1:0] lim;
    logic          in_rng, aligned, owned_w;
    logic [IW-1:0] idx_w, swp_nx, rd_link;
    logic [SW-1:0] acq_sum;

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_we;
    assign acc         = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    assign cfg_rebuild = i_cfg_we && ((i_cfg_index == CFG_BASE) ||
                         (i_cfg_index == CFG_CAPACITY) || (i_cfg_index == CFG_SIZE_LOG2) ||
                         (i_cfg_index == CFG_ALIGN_LOG2));
    assign cfg_ok = (r_slog >= LOG2_W'(MIN_BLOCK_LOG2)) &&
                    (r_alog >= LOG2_W'(MIN_BLOCK_LOG2)) && (r_alog <= r_slog);

    assign base_x  = XW'(r_base) & AMASK;
    assign sz_m1   = (XW'(1) << r_slog) - XW'(1);
    assign cap_sh  = r_cap >> r_slog;
    assign fit     = r_rem >> r_slog;
    assign acq_sum = (SW'(base_x) + (SW'(r_head) << r_slog)) & SW'(AMASK);

    assign lim     = LKW'(r_count) << r_slog;
    assign in_rng  = !r_lt && (LKW'(r_off) < lim);
    assign aligned = ((r_off & sz_m1) == '0);
    assign owned_w = in_rng && aligned;
    assign idx_w   = IW'(r_off >> r_slog);

    assign swp_nx  = r_swp + IW'(1);
    assign rd_link = ram_rdata[MW-1:1];

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_free    = r_free;
        n_count   = r_count;
        n_swp     = r_swp;
        n_rbitem  = r_rbitem;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AI-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_head[AI-1:0];
        put       = 1'b0;
        put_item  = mk_out(ST_OK, '0, 1'b0, r_free, r_count);
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.operation)
                        OP_ACQUIRE: begin
                            ram_re  = 1'b1;
                            n_state = S_RD;
                        end
                        OP_RESET: begin
                            n_rbitem = 1'b1;
                            n_state  = S_CNTA;
                        end
                        default: n_state = S_LKA;
                    endcase
                end
            end
            S_CNTA: n_state = S_CNTB;
            S_CNTB: n_state = S_CNTC;
            S_CNTC: begin
                if (r_under) begin
                    n_count = '0;
                end else if (fit >= XW'(r_ncap)) begin
                    n_count = r_ncap;
                end else begin
                    n_count = IW'(fit) + IW'(1);
                end
                n_swp   = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_swp[AI-1:0];
                ram_wdata = {(swp_nx < r_count) ? swp_nx : NULL_I, r_swp < r_count};
                if (r_swp == LAST_I) begin
                    n_head = (r_count != '0) ? '0 : NULL_I;
                    n_free = r_count;
                    if (!r_rbitem || out_free) begin
                        put      = r_rbitem;
                        put_item = mk_out(ST_OK, '0, 1'b0, r_count, r_count);
                        n_rbitem = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_swp = swp_nx;
                end
            end
            S_LKA: n_state = S_LKB;
            S_LKB: begin
                if (r_op == OP_CHECK) begin
                    if (out_free) begin
                        put      = 1'b1;
                        put_item = mk_out(ST_OK, '0, owned_w, r_free, r_count);
                        n_state  = S_IDLE;
                    end
                end else if (r_addr == '0 || !owned_w) begin
                    if (out_free) begin
                        put      = 1'b1;
                        put_item = mk_out((r_addr == '0) ? ST_NULL : ST_INVALID, '0,
                                          owned_w, r_free, r_count);
                        n_state  = S_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_w[AI-1:0];
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                if (out_free) begin
                    put     = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_ACQUIRE) begin
                        if (r_exh) begin
                            put_item = mk_out(ST_EXHAUSTED, '0, 1'b0, r_free, r_count);
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_head[AI-1:0];
                            ram_wdata = {rd_link, 1'b0};
                            n_head    = (rd_link < r_count) ? rd_link : NULL_I;
                            n_free    = r_free - IW'(1);
                            put_item  = mk_out(ST_OK, r_raddr, 1'b0, n_free, r_count);
                        end
                    end else if (r_drc && ram_rdata[0]) begin
                        put_item = mk_out(ST_DOUBLE, '0, 1'b1, r_free, r_count);
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx[AI-1:0];
                        ram_wdata = {(r_head < r_count) ? r_head : NULL_I, 1'b1};
                        n_head    = r_idx;
                        n_free    = (r_free < r_count) ? r_free + IW'(1) : r_free;
                        put_item  = mk_out(ST_OK, '0, 1'b1, n_free, r_count);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (cfg_rebuild) begin
            n_state  = S_CNTA;
            n_rbitem = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CNTA;
            r_base   <= BASE_RST;
            r_cap    <= CAP_RST;
            r_slog   <= SIZE_RST;
            r_alog   <= ALIGN_RST;
            r_drc    <= DRC_RST;
            r_head   <= NULL_I;
            r_free   <= '0;
            r_count  <= '0;
            r_swp    <= '0;
            r_rbitem <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_free   <= n_free;
            r_count  <= n_count;
            r_swp    <= n_swp;
            r_rbitem <= n_rbitem;
            if (put) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:       r_base <= i_cfg_data;
                    CFG_CAPACITY:   r_cap  <= i_cfg_data;
                    CFG_SIZE_LOG2:  r_slog <= i_cfg_data[LOG2_W-1:0];
                    CFG_ALIGN_LOG2: r_alog <= i_cfg_data[LOG2_W-1:0];
                    CFG_DRC:        r_drc  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (put) begin
            r_out <= put_item;
        end
        if (acc) begin
            r_op    <= i_in.operation;
            r_addr  <= XW'(i_in.address) & AMASK;
            r_raddr <= acq_sum[31:0];
            r_exh   <= (r_free == '0) || (r_head >= r_count);
        end
        if (r_state == S_LKA) begin
            r_lt  <= r_addr < base_x;
            r_off <= r_addr - base_x;
        end
        if (r_state == S_LKB) begin
            r_idx <= idx_w;
        end
        if (r_state == S_CNTA) begin
            r_space <= AMASK - base_x;
            r_ncap  <= (cap_sh > 32'(NUM_BLOCKS)) ? NULL_I : IW'(cap_sh);
        end
        if (r_state == S_CNTB) begin
            r_rem   <= r_space - sz_m1;
            r_under <= (r_space < sz_m1) || !cfg_ok;
        end
    end

    fbpa_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    a_free_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_free <= r_count)
        else $error("free count above block count");

    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_swp == LAST_I && !i_cfg_we) |=> r_free == r_count)
        else $error("rebuild left blocks in use");

    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_EXHAUSTED) |->
        (o_out.block_address == '0 && !o_out.owned))
        else $error("failed acquire carries an address");

    a_read_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_re && !i_cfg_we) |=> r_state == S_RD)
        else $error("link read not consumed");

endmodule

@@ tb/fixed_block_pool_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top_tb
// Self-checking bench for the block pool allocator. A shadow copy of the free
// list, counts and free map predicts every result beat from the accepted
// request beats. Runs a short directed script, then edge setups of the pool
// registers and random setups with mostly well-formed release addresses.
// Both sides idle in random bursts; the final phase runs without idling.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top_tb;
    import fbpa_pkg::*;

    localparam int NB            = NUM_BLOCKS_DEF;
    localparam int REBUILD_WAIT  = NB + 8;
    localparam int SETTLE_CYCLES = 16;

    class pool_shadow;
        logic [31:0]       base;
        logic [31:0]       capacity;
        logic [LOG2_W-1:0] size_log2;
        logic [LOG2_W-1:0] align_log2;
        bit                drc;
        int unsigned       link [NB];
        bit                is_free [NB];
        int unsigned       head;
        int unsigned       free_cnt;
        int unsigned       blocks;
        t_out_item         replies [$];
        int                errors;

        function new();
            base       = BASE_RST;
            capacity   = CAP_RST;
            size_log2  = SIZE_RST;
            align_log2 = ALIGN_RST;
            drc        = DRC_RST;
            errors     = 0;
            rebuild();
        endfunction

        function int unsigned count_blocks();
            logic [63:0] sz;
            logic [63:0] room;
            logic [63:0] n;
            logic [63:0] fit;
            if (size_log2 < MIN_BLOCK_LOG2 || align_log2 < MIN_BLOCK_LOG2 ||
                align_log2 > size_log2) begin
                return 0;
            end
            sz = 64'd1 << size_log2;
            n  = {32'd0, capacity} >> size_log2;
            if (n > 64'(NB)) begin
                n = 64'(NB);
            end
            room = 64'hFFFF_FFFF - {32'd0, base};
            if (room < sz - 1) begin
                return 0;
            end
            fit = ((room - (sz - 1)) >> size_log2) + 1;
            if (n > fit) begin
                n = fit;
            end
            return n[31:0];
        endfunction

        function void rebuild();
            blocks = count_blocks();
            for (int i = 0; i < NB; i++) begin
                link[i]    = (i + 1 < blocks) ? i + 1 : NB;
                is_free[i] = (i < blocks);
            end
            head     = (blocks != 0) ? 0 : NB;
            free_cnt = blocks;
        endfunction

        function bit find_block(logic [31:0] addr, output int unsigned idx);
            logic [63:0] off;
            idx = 0;
            if (addr < base) begin
                return 0;
            end
            off = {32'd0, addr - base};
            if (off >= ({32'd0, blocks} << size_log2)) begin
                return 0;
            end
            if ((off & ((64'd1 << size_log2) - 1)) != 0) begin
                return 0;
            end
            off = off >> size_log2;
            idx = off[31:0];
            return 1;
        endfunction

        function void configure(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_BASE: begin
                    base = data;
                    rebuild();
                end
                CFG_CAPACITY: begin
                    capacity = data;
                    rebuild();
                end
                CFG_SIZE_LOG2: begin
                    size_log2 = data[LOG2_W-1:0];
                    rebuild();
                end
                CFG_ALIGN_LOG2: begin
                    align_log2 = data[LOG2_W-1:0];
                    rebuild();
                end
                CFG_DRC: begin
                    drc = data[0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_request(t_in_item req);
            t_out_item   r;
            int unsigned idx;
            bit          hit;
            logic [63:0] a;
            r = '0;
            r.status = ST_OK;
            case (req.operation)
                OP_ACQUIRE: begin
                    if (free_cnt == 0 || head >= blocks) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        idx = head;
                        a = {32'd0, base} + ({32'd0, idx} << size_log2);
                        r.block_address = a[31:0];
                        head = (link[idx] < blocks) ? link[idx] : NB;
                        free_cnt--;
                        is_free[idx] = 1'b0;
                    end
                end
                OP_RELEASE: begin
                    hit = find_block(req.address, idx);
                    r.owned = hit;
                    if (req.address == 32'd0) begin
                        r.status = ST_NULL;
                    end else if (!hit) begin
                        r.status = ST_INVALID;
                    end else if (drc && is_free[idx]) begin
                        r.status = ST_DOUBLE;
                    end else begin
                        link[idx]    = (head < blocks) ? head : NB;
                        head         = idx;
                        is_free[idx] = 1'b1;
                        if (free_cnt < blocks) begin
                            free_cnt++;
                        end
                    end
                end
                OP_RESET: begin
                    rebuild();
                end
                default: begin
                    r.owned = find_block(req.address, idx);
                end
            endcase
            r.free_blocks = free_cnt[CNT_W-1:0];
            r.used_blocks = CNT_W'(blocks - free_cnt);
            r.pool_empty  = (blocks == free_cnt);
            r.pool_full   = (free_cnt == 0);
            replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (replies.size() == 0) begin
                $display("%0t: result beat expected none got %p", $time, got);
                errors++;
                return;
            end
            want = replies.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("block_address", want.block_address, got.block_address);
            compare_field("owned", 32'(want.owned), 32'(got.owned));
            compare_field("free_blocks", 32'(want.free_blocks), 32'(got.free_blocks));
            compare_field("used_blocks", 32'(want.used_blocks), 32'(got.used_blocks));
            compare_field("pool_empty", 32'(want.pool_empty), 32'(got.pool_empty));
            compare_field("pool_full", 32'(want.pool_full), 32'(got.pool_full));
        endfunction

        function int pending();
            return replies.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    pool_shadow shadow;
    bit         idle_on;
    int         stall_run;

    fixed_block_pool_allocator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_out_stall = 1'b0;
        stall_run   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_run > 0) begin
                stall_run--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_run = $urandom_range(0, 10);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            shadow.check_result(o_out);
        end
    end

    function automatic t_in_item mk(t_op op, logic [31:0] addr);
        t_in_item req;
        req.operation = op;
        req.address   = addr;
        return req;
    endfunction

    function automatic logic [31:0] pick_address();
        logic [63:0] a;
        logic [31:0] mask;
        int unsigned idx;
        int          r;
        r = $urandom_range(0, 99);
        if (shadow.blocks == 0 || r >= 88) begin
            return $urandom;
        end
        if (r < 8) begin
            return 32'd0;
        end
        idx = $urandom_range(0, shadow.blocks - 1);
        if (r < 55) begin
            for (int t = 0; t < 4 && shadow.is_free[idx]; t++) begin
                idx = $urandom_range(0, shadow.blocks - 1);
            end
        end
        mask = (32'd1 << shadow.size_log2) - 1;
        a = {32'd0, shadow.base} + ({32'd0, idx} << shadow.size_log2);
        if (r >= 55 && r < 64) begin
            a = a + 1 + ($urandom % mask);
        end else if (r >= 64 && r < 72) begin
            a = {32'd0, shadow.base} + ({32'd0, shadow.blocks} << shadow.size_log2) +
                (64'($urandom_range(0, 3)) << shadow.size_log2);
        end else if (r >= 72 && r < 80) begin
            a = {32'd0, shadow.base} - $urandom_range(1, 64);
        end
        return a[31:0];
    endfunction

    function automatic t_in_item pick_item(int acq_w, int rel_w, int chk_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < acq_w) begin
            return mk(OP_ACQUIRE, $urandom);
        end else if (r < acq_w + rel_w) begin
            return mk(OP_RELEASE, pick_address());
        end else if (r < acq_w + rel_w + chk_w) begin
            return mk(OP_CHECK, pick_address());
        end
        return mk(OP_RESET, $urandom);
    endfunction

    task automatic send(t_in_item req);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        shadow.note_request(req);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        drain();
        repeat (REBUILD_WAIT) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow.configure(idx, data);
    endtask

    task automatic apply_setup(logic [31:0] b, logic [31:0] c, logic [31:0] s,
                               logic [31:0] al, logic [31:0] d);
        write_reg(CFG_BASE, b);
        write_reg(CFG_CAPACITY, c);
        write_reg(CFG_SIZE_LOG2, s);
        write_reg(CFG_ALIGN_LOG2, al);
        write_reg(CFG_DRC, d);
    endtask

    task automatic random_setup();
        logic [31:0] s;
        logic [31:0] al;
        logic [31:0] b;
        logic [31:0] c;
        s  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 7);
        al = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
             $urandom_range(2, (s < 2) ? 2 : s);
        b  = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'h00FF_FFFF);
        c  = ($urandom_range(0, 5) == 0) ? $urandom :
             ((32'($urandom_range(0, 40)) << s[4:0]) + $urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
            s  = ($urandom & 32'hFFFF_FFE0) | s;
            al = ($urandom & 32'hFFFF_FFE0) | al;
        end
        apply_setup(b, c, s, al, $urandom);
    endtask

    task automatic run_phase(int n, int acq_w, int rel_w, int chk_w);
        for (int k = 0; k < n; k++) begin
            if (idle_on && $urandom_range(0, 99) == 0) begin
                drain();
            end
            send(pick_item(acq_w, rel_w, chk_w));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        shadow      = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(mk(OP_ACQUIRE, 32'd0));
        send(mk(OP_RELEASE, 32'd0));
        send(mk(OP_ACQUIRE, 32'hFFFF_FFFF));
        send(mk(OP_RELEASE, 32'd64));
        send(mk(OP_RELEASE, 32'd64));
        send(mk(OP_CHECK, 32'd64));
        send(mk(OP_CHECK, 32'd65));
        send(mk(OP_CHECK, 32'd32768));
        send(mk(OP_RELEASE, 32'hFFFF_FFFF));
        send(mk(OP_RELEASE, 32'd3));
        send(mk(OP_RESET, 32'd0));
        send(mk(OP_ACQUIRE, 32'd0));

        apply_setup(32'h0000_1000, 32'd64, 32'd4, 32'd2, 32'd0);
        repeat (5) send(mk(OP_ACQUIRE, 32'd0));
        send(mk(OP_RELEASE, 32'h0000_1000));
        send(mk(OP_RELEASE, 32'h0000_1000));
        send(mk(OP_RELEASE, 32'h0000_0FFF));
        send(mk(OP_RELEASE, 32'h0000_1040));
        send(mk(OP_ACQUIRE, 32'd0));
        send(mk(OP_ACQUIRE, 32'd0));

        apply_setup(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd2, 32'd2, 32'd1);
        run_phase(30, 40, 35, 20);
        apply_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16, 32'd16, 32'd0);
        run_phase(20, 40, 35, 20);
        apply_setup(32'd0, 32'hFFFF_FFFF, 32'd16, 32'd16, 32'd1);
        run_phase(30, 40, 35, 20);
        apply_setup(32'h8000_0000, 32'hFFFF_FFFF, 32'd31, 32'd31, 32'd0);
        run_phase(25, 40, 35, 20);
        apply_setup(32'h0000_0100, 32'd0, 32'd0, 32'd3, 32'd1);
        run_phase(20, 40, 35, 20);

        for (int p = 0; p < 10; p++) begin
            idle_on = (p == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
            random_setup();
            run_phase(112, 40, 37, 20);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
